@@ rtl/core/fbc_pkg.sv @@
// ----------------------------------------------------------------------------
// fbc_pkg
// Shared types and constants for the frustum box cull test.
// ----------------------------------------------------------------------------
`default_nettype none

package fbc_pkg;

  // Plane register layout and config port
  localparam int FIELD_W     = 16;
  localparam int CFG_W       = 64;
  localparam int REG_COUNT   = 6;
  localparam int CFG_IDX_W   = 3;
  localparam int OUT_TDATA_W = 8;

  // Register indexes on the config port
  typedef enum logic [CFG_IDX_W-1:0] {
    PL_LEFT   = 3'd0,
    PL_RIGHT  = 3'd1,
    PL_TOP    = 3'd2,
    PL_BOTTOM = 3'd3,
    PL_FAR    = 3'd4,
    PL_NEAR   = 3'd5
  } plane_idx_e_t;

  // nx in bits 15:0 up to d in bits 63:48
  typedef struct packed {
    logic signed [FIELD_W-1:0] d;
    logic signed [FIELD_W-1:0] nz;
    logic signed [FIELD_W-1:0] ny;
    logic signed [FIELD_W-1:0] nx;
  } plane_t;

  // Per-stage load enables from the top-level flow control
  typedef struct packed {
    logic s1_en;
    logic s2_en;
    logic s3_en;
    logic s4_en;
  } pipe_ctl_t;

endpackage

`default_nettype wire

@@ rtl/core/fbc_cfg.sv @@
// ----------------------------------------------------------------------------
// fbc_cfg
// Plane register file: six 64-bit plane words, cleared on reset.
// ----------------------------------------------------------------------------
`default_nettype none

module fbc_cfg (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  cfg_wr_en,
  input  wire  [fbc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire  [fbc_pkg::CFG_W-1:0]            cfg_wdata,
  output fbc_pkg::plane_t                      planes [fbc_pkg::REG_COUNT]
);
  import fbc_pkg::*;

  plane_t plane_r [REG_COUNT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < REG_COUNT; i++) begin
        plane_r[i] <= '0;
      end
    end else if (cfg_wr_en && (cfg_index <= PL_NEAR)) begin
      // indexes past the near plane are dropped
      plane_r[cfg_index] <= plane_t'(cfg_wdata);
    end
  end

  always_comb begin
    for (int i = 0; i < REG_COUNT; i++) begin
      planes[i] = plane_r[i];
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/fbc_front.sv @@
// ----------------------------------------------------------------------------
// fbc_front
// Input stage: unpacks the box item and registers center and |half extent|.
// ----------------------------------------------------------------------------
`default_nettype none

module fbc_front #(
  parameter int COORD_BITS = 16
) (
  input  wire                                          clk,
  input  fbc_pkg::pipe_ctl_t                           ctl,
  input  wire  [((6*COORD_BITS+7)/8)*8-1:0]            tdata,
  output logic signed [COORD_BITS-1:0]                 c_r  [3],
  output logic        [COORD_BITS-1:0]                 hm_r [3]
);
  import fbc_pkg::*;

  logic signed [COORD_BITS-1:0] c_nxt  [3];
  logic        [COORD_BITS-1:0] hm_nxt [3];
  logic        [COORD_BITS-1:0] h_raw  [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      c_nxt[i] = $signed(tdata[i*COORD_BITS +: COORD_BITS]);
      h_raw[i] = tdata[(i+3)*COORD_BITS +: COORD_BITS];
      // most negative value maps to its magnitude as an unsigned pattern
      hm_nxt[i] = h_raw[i][COORD_BITS-1] ? (~h_raw[i] + 1'b1) : h_raw[i];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.s1_en) begin
      for (int i = 0; i < 3; i++) begin
        c_r[i]  <= c_nxt[i];
        hm_r[i] <= hm_nxt[i];
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/fbc_plane.sv @@
// ----------------------------------------------------------------------------
// fbc_plane
// One plane test: products, distance and radius sums, then the cull compare.
// ----------------------------------------------------------------------------
`default_nettype none

module fbc_plane #(
  parameter int COORD_BITS       = 16,
  parameter int NORMAL_FRAC_BITS = 14
) (
  input  wire                             clk,
  input  fbc_pkg::pipe_ctl_t              ctl,
  input  fbc_pkg::plane_t                 plane,
  input  wire signed [COORD_BITS-1:0]     c  [3],
  input  wire        [COORD_BITS-1:0]     hm [3],
  output logic                            cull_r
);
  import fbc_pkg::*;

  localparam int PC_W  = COORD_BITS + FIELD_W;
  localparam int PH_W  = COORD_BITS + FIELD_W;
  localparam int RAD_W = COORD_BITS + FIELD_W;
  localparam int DSH_W = FIELD_W + NORMAL_FRAC_BITS;
  localparam int ACC_W = ((PC_W > DSH_W) ? PC_W : DSH_W) + 3;
  localparam int SUM_W = ACC_W + 1;

  logic signed [FIELD_W-1:0] n      [3];
  logic        [FIELD_W-1:0] n_mag  [3];
  logic signed [PC_W-1:0]    prod_c_nxt [3];
  logic signed [PC_W-1:0]    prod_c_r   [3];
  logic        [PH_W-1:0]    prod_h_nxt [3];
  logic        [PH_W-1:0]    prod_h_r   [3];
  logic signed [ACC_W-1:0]   dist_nxt;
  logic signed [ACC_W-1:0]   dist_r;
  logic        [RAD_W-1:0]   rad_nxt;
  logic        [RAD_W-1:0]   rad_r;
  logic signed [SUM_W-1:0]   margin;
  logic                      cull_nxt;

  // normal magnitudes come from static config
  always_comb begin
    n[0] = plane.nx;
    n[1] = plane.ny;
    n[2] = plane.nz;
    for (int i = 0; i < 3; i++) begin
      n_mag[i] = n[i][FIELD_W-1] ? (~n[i] + 1'b1) : n[i];
    end
  end

  // stage 2: multipliers
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prod_c_nxt[i] = PC_W'(c[i]) * PC_W'(n[i]);
      prod_h_nxt[i] = PH_W'(hm[i]) * PH_W'(n_mag[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.s2_en) begin
      for (int i = 0; i < 3; i++) begin
        prod_c_r[i] <= prod_c_nxt[i];
        prod_h_r[i] <= prod_h_nxt[i];
      end
    end
  end

  // stage 3: dist = c.n - d * 2^frac, rad = sum |h|*|n|
  always_comb begin
    dist_nxt = ACC_W'(prod_c_r[0]) + ACC_W'(prod_c_r[1]) + ACC_W'(prod_c_r[2])
             - (ACC_W'(plane.d) <<< NORMAL_FRAC_BITS);
    rad_nxt  = prod_h_r[0] + prod_h_r[1] + prod_h_r[2];
  end

  always_ff @(posedge clk) begin
    if (ctl.s3_en) begin
      dist_r <= dist_nxt;
      rad_r  <= rad_nxt;
    end
  end

  // stage 4: culled when dist < -rad, i.e. dist + rad negative
  always_comb begin
    margin   = $signed(SUM_W'(dist_r)) + $signed(SUM_W'(rad_r));
    cull_nxt = margin[SUM_W-1];
  end

  always_ff @(posedge clk) begin
    if (ctl.s4_en) begin
      cull_r <= cull_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/frustum_box_cull_test.sv @@
// ----------------------------------------------------------------------------
// frustum_box_cull_test
// Five register stages from input accept to out_tvalid: input reg, multiply,
// sum, compare, output reg. Throughput: one item per cycle while the output
// is not stalled; each stage has its own valid bit, so bubbles close up while
// the output is stalled.
// Reset clears all valid bits and the six plane registers to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module frustum_box_cull_test #(
  parameter int PLANE_COUNT      = 6,
  parameter int COORD_BITS       = 16,
  parameter int NORMAL_FRAC_BITS = 14
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  // config write port
  input  wire                                   cfg_wr_en,
  input  wire  [fbc_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire  [fbc_pkg::CFG_W-1:0]             cfg_wdata,
  // box item in
  input  wire                                   in_tvalid,
  output logic                                  in_tready,
  // center_x, center_y, center_z, half_x, half_y, half_z (COORD_BITS each)
  input  wire  [((6*COORD_BITS+7)/8)*8-1:0]     in_tdata,
  // result out
  output logic                                  out_tvalid,
  input  wire                                   out_tready,
  // bit 0: visible, rest zero
  output logic [fbc_pkg::OUT_TDATA_W-1:0]       out_tdata
);
  import fbc_pkg::*;

  // plane slots past the register file always pass
  localparam int NUM_PLANES = (PLANE_COUNT < REG_COUNT) ? PLANE_COUNT : REG_COUNT;

  plane_t                  planes [REG_COUNT];
  pipe_ctl_t               ctl;
  logic signed [COORD_BITS-1:0] c_s1  [3];
  logic        [COORD_BITS-1:0] hm_s1 [3];
  logic [NUM_PLANES-1:0]   cull_vec;

  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;
  logic visible_r;
  logic visible_nxt;

  // ready chain: a stage loads when it is empty or the next one moves
  always_comb begin
    rdy5      = !v5_r || out_tready;
    rdy4      = !v4_r || rdy5;
    rdy3      = !v3_r || rdy4;
    rdy2      = !v2_r || rdy3;
    rdy1      = !v1_r || rdy2;
    in_tready = rdy1;
    ctl.s1_en = rdy1;
    ctl.s2_en = rdy2;
    ctl.s3_en = rdy3;
    ctl.s4_en = rdy4;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_tvalid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
      if (rdy5) v5_r <= v4_r;
    end
  end

  fbc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .planes    (planes)
  );

  fbc_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk   (clk),
    .ctl   (ctl),
    .tdata (in_tdata),
    .c_r   (c_s1),
    .hm_r  (hm_s1)
  );

  for (genvar p = 0; p < NUM_PLANES; p++) begin : g_plane
    fbc_plane #(
      .COORD_BITS       (COORD_BITS),
      .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
    ) u_plane (
      .clk    (clk),
      .ctl    (ctl),
      .plane  (planes[p]),
      .c      (c_s1),
      .hm     (hm_s1),
      .cull_r (cull_vec[p])
    );
  end

  // stage 5: any plane that culls hides the box
  assign visible_nxt = ~|cull_vec;

  always_ff @(posedge clk) begin
    if (rdy5) begin
      visible_r <= visible_nxt;
    end
  end

  assign out_tvalid = v5_r;
  assign out_tdata  = {{(OUT_TDATA_W-1){1'b0}}, visible_r};

  // back-pressure at the input only when every stage holds an item
  a_full_when_blocked : assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (v1_r && v2_r && v3_r && v4_r && out_tvalid))
    else $error("input blocked while pipeline has a bubble");

  a_reset_empty : assert property (@(posedge clk)
    !rst_n |=> (in_tready && !out_tvalid))
    else $error("pipeline not empty after reset");

  a_stage4_drains : assert property (@(posedge clk) disable iff (!rst_n)
    (v4_r && rdy5) |=> out_tvalid)
    else $error("item lost between compare stage and output");

  a_no_phantom : assert property (@(posedge clk) disable iff (!rst_n)
    (!v4_r && rdy5) |=> !out_tvalid)
    else $error("result produced without an item");

endmodule

`default_nettype wire

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the frustum versus box cull test.
// Boxes stream in under several plane settings (reset zeros, axis-aligned
// frustums, skewed and unnormalized planes, bit-pattern extremes). Each
// accepted box gets a visibility prediction that is checked in order against
// the result stream, with random stalls on both sides and one long output hold.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fbc_pkg::*;

  localparam int COORD_W     = 16;
  localparam int FRAC_BITS   = 14;
  localparam int ONE_Q14     = 1 << FRAC_BITS;
  localparam int LONG_HOLD   = 200;
  localparam int TAIL_CYCLES = 20;
  localparam int STALL_LIMIT = 5000;

  // indexes past the last plane; writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_HI = 3'd7;

  typedef enum int {IDLE_NONE, IDLE_RANDOM} idle_mode_t;
  typedef enum int {SET_BOX, SET_BOX_NO_NEAR, SET_SKEWED, SET_EXTREME} plane_set_t;

  // cx in the lowest bits, hz in the highest
  typedef struct packed {
    logic signed [COORD_W-1:0] hz, hy, hx, cz, cy, cx;
  } box_t;

  logic                    clk       = 1'b0;
  logic                    rst_n     = 1'b0;
  logic                    cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [CFG_W-1:0]        cfg_wdata = '0;
  logic                    in_tvalid = 1'b0;
  logic                    in_tready;
  logic [$bits(box_t)-1:0] in_tdata  = '0;
  logic                    out_tvalid;
  logic                    out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0]  out_tdata;

  logic [CFG_W-1:0] plane_shadow [REG_COUNT];
  box_t             box_queue [$];
  logic             vis_expect [$];

  idle_mode_t src_mode  = IDLE_NONE;
  idle_mode_t sink_mode = IDLE_NONE;
  int src_gap     = 0;
  int sink_stall  = 0;
  int hold_left   = 0;
  int holds_asked = 0;
  int holds_seen  = 0;
  int stalled     = 0;
  int n_errors    = 0;
  int n_checked   = 0;
  int n_visible   = 0;
  int n_settings  = 0;
  logic want;

  frustum_box_cull_test dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // box survives unless some plane has distance < -radius
  function automatic logic box_in_view(box_t b);
    plane_t p;
    longint c [3];
    longint h [3];
    longint n [3];
    longint sdist, rad;
    logic   vis;
    int     i, k;
    c[0] = $signed(b.cx);
    c[1] = $signed(b.cy);
    c[2] = $signed(b.cz);
    h[0] = $signed(b.hx);
    h[1] = $signed(b.hy);
    h[2] = $signed(b.hz);
    vis  = 1'b1;
    for (k = 0; k < 3; k++)
      if (h[k] < 0) h[k] = -h[k];
    for (i = 0; i < REG_COUNT; i++) begin
      p     = plane_t'(plane_shadow[i]);
      n[0]  = $signed(p.nx);
      n[1]  = $signed(p.ny);
      n[2]  = $signed(p.nz);
      sdist = -(longint'($signed(p.d)) * ONE_Q14);
      rad   = 0;
      for (k = 0; k < 3; k++) begin
        sdist += c[k] * n[k];
        rad   += h[k] * ((n[k] < 0) ? -n[k] : n[k]);
      end
      if (sdist < -rad) vis = 1'b0;
    end
    return vis;
  endfunction

  function automatic logic [CFG_W-1:0] make_plane(int nx, int ny, int nz, int d);
    plane_t p;
    p.nx = nx[FIELD_W-1:0];
    p.ny = ny[FIELD_W-1:0];
    p.nz = nz[FIELD_W-1:0];
    p.d  = d[FIELD_W-1:0];
    return p;
  endfunction

  function automatic box_t mk_box(int cx, int cy, int cz, int hx, int hy, int hz);
    box_t b;
    b.cx = cx[COORD_W-1:0];
    b.cy = cy[COORD_W-1:0];
    b.cz = cz[COORD_W-1:0];
    b.hx = hx[COORD_W-1:0];
    b.hy = hy[COORD_W-1:0];
    b.hz = hz[COORD_W-1:0];
    return b;
  endfunction

  function automatic logic [COORD_W-1:0] pick_center();
    if ($urandom_range(0, 3) == 0) return COORD_W'($urandom);
    return COORD_W'(int'($urandom_range(0, 12000)) - 6000);
  endfunction

  function automatic logic [COORD_W-1:0] pick_half();
    int v;
    if ($urandom_range(0, 4) < 2) return COORD_W'($urandom);
    v = $urandom_range(0, 3000);
    if ($urandom_range(0, 1) == 1) v = -v;
    return COORD_W'(v);
  endfunction

  function automatic box_t random_box();
    box_t b;
    b.cx = pick_center();
    b.cy = pick_center();
    b.cz = pick_center();
    b.hx = pick_half();
    b.hy = pick_half();
    b.hz = pick_half();
    return b;
  endfunction

  // mostly back to back, some short gaps, a few long ones
  function automatic int idle_len(idle_mode_t m);
    int r;
    r = $urandom_range(0, 99);
    if (m == IDLE_NONE || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      src_gap   <= 0;
    end else begin
      if (in_tvalid && in_tready)
        vis_expect.push_back(box_in_view(box_t'(in_tdata)));
      if (!in_tvalid || in_tready) begin
        if (src_gap > 0) begin
          src_gap   <= src_gap - 1;
          in_tvalid <= 1'b0;
        end else if (box_queue.size() > 0) begin
          in_tdata  <= box_queue.pop_front();
          in_tvalid <= 1'b1;
          src_gap   <= idle_len(src_mode);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: random stalls, plus a long hold whenever one is requested
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      sink_stall <= 0;
      hold_left  <= 0;
      holds_seen <= 0;
    end else if (holds_asked != holds_seen) begin
      holds_seen <= holds_asked;
      hold_left  <= LONG_HOLD;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (sink_stall > 0) begin
      sink_stall <= sink_stall - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      sink_stall <= idle_len(sink_mode);
    end
  end

  // result check
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (vis_expect.size() == 0) begin
        $error("unexpected item: visible=%0d", out_tdata[0]);
        n_errors++;
      end else begin
        want = vis_expect.pop_front();
        if (out_tdata[0] !== want) begin
          $error("visible: expected %0d, got %0d", want, out_tdata[0]);
          n_errors++;
        end
        n_checked++;
        if (want) n_visible++;
      end
    end
  end

  // watchdog: only counts while work is outstanding
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (box_queue.size() == 0 && !in_tvalid && vis_expect.size() == 0)) begin
      stalled <= 0;
    end else if (stalled >= STALL_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
      $display("tb: FAIL");
      $finish;
    end else begin
      stalled <= stalled + 1;
    end
  end

  task automatic wait_drained();
    do @(negedge clk);
    while (box_queue.size() != 0 || in_tvalid || vis_expect.size() != 0);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx < REG_COUNT) plane_shadow[idx] = val;
  endtask

  task automatic cfg_close();
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    n_settings++;
  endtask

  task automatic apply_planes(input logic [CFG_W-1:0] pl [REG_COUNT]);
    cfg_write(PL_LEFT,   pl[PL_LEFT]);
    cfg_write(PL_RIGHT,  pl[PL_RIGHT]);
    cfg_write(PL_TOP,    pl[PL_TOP]);
    cfg_write(PL_BOTTOM, pl[PL_BOTTOM]);
    cfg_write(PL_FAR,    pl[PL_FAR]);
    cfg_write(PL_NEAR,   pl[PL_NEAR]);
    cfg_close();
  endtask

  task automatic pick_planes(input plane_set_t kind, input int pattern,
                             output logic [CFG_W-1:0] pl [REG_COUNT]);
    logic [CFG_W-1:0] extremes [4];
    int lo_x, hi_x, lo_y, hi_y, lo_z, hi_z, i;
    extremes = '{64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_8000_8000_8000,
                 64'h7FFF_7FFF_7FFF_7FFF, 64'h7FFF_8000_7FFF_8000};
    lo_x = -int'($urandom_range(200, 30000));
    hi_x = $urandom_range(200, 30000);
    lo_y = -int'($urandom_range(200, 30000));
    hi_y = $urandom_range(200, 30000);
    lo_z = $urandom_range(0, 2000);
    hi_z = $urandom_range(3000, 32000);
    case (kind)
      SET_BOX, SET_BOX_NO_NEAR: begin
        pl[PL_LEFT]   = make_plane(ONE_Q14, 0, 0, lo_x);
        pl[PL_RIGHT]  = make_plane(-ONE_Q14, 0, 0, -hi_x);
        pl[PL_TOP]    = make_plane(0, -ONE_Q14, 0, -hi_y);
        pl[PL_BOTTOM] = make_plane(0, ONE_Q14, 0, lo_y);
        pl[PL_FAR]    = make_plane(0, 0, -ONE_Q14, -hi_z);
        pl[PL_NEAR]   = (kind == SET_BOX_NO_NEAR) ? '0 : make_plane(0, 0, ONE_Q14, lo_z);
      end
      SET_SKEWED: begin
        // arbitrary normals, no normalization; about a quarter of planes unused
        for (i = 0; i < REG_COUNT; i++)
          pl[i] = ($urandom_range(0, 3) == 0) ? '0 : {$urandom, $urandom};
      end
      default: begin
        for (i = 0; i < REG_COUNT; i++)
          pl[i] = extremes[pattern % 4];
      end
    endcase
  endtask

  task automatic run_phase(input plane_set_t kind, input int pattern, input int count,
                           input idle_mode_t src, input idle_mode_t snk,
                           input bit hold, input bit split);
    logic [CFG_W-1:0] pl [REG_COUNT];
    int i;
    pick_planes(kind, pattern, pl);
    apply_planes(pl);
    @(negedge clk);
    src_mode  = src;
    sink_mode = snk;
    for (i = 0; i < count; i++) begin
      // sender waits for the pipe to empty halfway through
      if (split && i == count / 2) wait_drained();
      box_queue.push_back(random_box());
    end
    if (hold) begin
      @(posedge clk);
      holds_asked <= holds_asked + 1;
    end
    wait_drained();
  endtask

  initial begin
    logic [CFG_W-1:0] pl [REG_COUNT];
    int i;
    for (i = 0; i < REG_COUNT; i++) plane_shadow[i] = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    n_settings = 1;

    // planes reset to zero, so every box passes
    @(negedge clk);
    for (i = 0; i < 8; i++) box_queue.push_back(random_box());
    wait_drained();

    // fixed frustum: |x| <= 1000, |y| <= 2000, 100 <= z <= 5000
    pl[PL_LEFT]   = make_plane(ONE_Q14, 0, 0, -1000);
    pl[PL_RIGHT]  = make_plane(-ONE_Q14, 0, 0, -1000);
    pl[PL_TOP]    = make_plane(0, -ONE_Q14, 0, -2000);
    pl[PL_BOTTOM] = make_plane(0, ONE_Q14, 0, -2000);
    pl[PL_FAR]    = make_plane(0, 0, -ONE_Q14, -5000);
    pl[PL_NEAR]   = make_plane(0, 0, ONE_Q14, 100);
    apply_planes(pl);
    src_mode  = IDLE_RANDOM;
    sink_mode = IDLE_RANDOM;
    @(negedge clk);
    box_queue.push_back(mk_box(0, 0, 0, 0, 0, 0));
    box_queue.push_back(mk_box(0, 0, 1000, 0, 0, 0));
    // touching the left plane exactly still counts as visible
    box_queue.push_back(mk_box(-1100, 0, 1000, 100, 0, 0));
    box_queue.push_back(mk_box(-1101, 0, 1000, 100, 0, 0));
    box_queue.push_back(mk_box(-1100, 0, 1000, -100, 0, 0));
    // most negative half extent means +32768
    box_queue.push_back(mk_box(-32768, 0, 1000, -32768, 0, 0));
    box_queue.push_back(mk_box(-32768, 0, 1000, 31767, 0, 0));
    box_queue.push_back(mk_box(-32768, 0, 1000, 31766, 0, 0));
    box_queue.push_back(mk_box(32767, 32767, 32767, 0, 0, 0));
    box_queue.push_back(mk_box(-32768, -32768, -32768, 0, 0, 0));
    box_queue.push_back(mk_box(32767, 32767, 32767, -32768, -32768, -32768));
    box_queue.push_back(mk_box(-32768, -32768, -32768, 32767, 32767, 32767));
    box_queue.push_back(mk_box(0, 0, 5100, 0, 0, 100));
    box_queue.push_back(mk_box(0, 0, 5100, 0, 0, 99));
    box_queue.push_back(mk_box(0, 2500, 1000, 0, 500, 0));
    box_queue.push_back(mk_box(0, 2500, 1000, 0, 499, 0));
    box_queue.push_back(mk_box(1000, -2000, 100, 0, 0, 0));
    wait_drained();

    // writes past the last plane are dropped; near plane switched off
    cfg_write(IDX_SPARE_LO, '1);
    cfg_write(IDX_SPARE_HI, '1);
    cfg_write(PL_NEAR, '0);
    cfg_close();
    @(negedge clk);
    box_queue.push_back(mk_box(0, 0, 0, 0, 0, 0));
    box_queue.push_back(mk_box(0, 0, -32768, 0, 0, 0));
    box_queue.push_back(mk_box(0, 0, 32767, 0, 0, 0));
    wait_drained();

    run_phase(SET_BOX,         0, 150, IDLE_RANDOM, IDLE_RANDOM, 1'b0, 1'b0);
    run_phase(SET_BOX_NO_NEAR, 0, 150, IDLE_NONE,   IDLE_NONE,   1'b0, 1'b0);
    run_phase(SET_SKEWED,      0, 150, IDLE_RANDOM, IDLE_NONE,   1'b0, 1'b0);
    // sender runs flat out into a long output hold
    run_phase(SET_BOX,         0, 150, IDLE_NONE,   IDLE_NONE,   1'b1, 1'b0);
    for (i = 0; i < 4; i++)
      run_phase(SET_EXTREME,   i, 25,  IDLE_RANDOM, IDLE_RANDOM, 1'b0, 1'b0);
    run_phase(SET_BOX,         0, 150, IDLE_RANDOM, IDLE_RANDOM, 1'b0, 1'b1);
    run_phase(SET_SKEWED,      0, 150, IDLE_NONE,   IDLE_RANDOM, 1'b0, 1'b0);
    run_phase(SET_BOX_NO_NEAR, 0, 150, IDLE_RANDOM, IDLE_RANDOM, 1'b0, 1'b0);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (vis_expect.size() != 0) begin
      $error("%0d results never arrived", vis_expect.size());
      n_errors++;
    end

    $display("summary: %0d boxes checked, %0d visible and %0d culled, %0d plane settings",
             n_checked, n_visible, n_checked - n_visible, n_settings);
    $display("summary: zero, axis-aligned, skewed and extreme planes; stalls and a long hold");
    if (n_errors == 0)
      $display("tb: PASS");
    else
      $display("tb: FAIL");
    $finish;
  end

endmodule
